/* hdl/cua_pkg.sv */
package cua_pkg;

    localparam int UNITS  = 65536;
    localparam int ADDR_W = $clog2(UNITS);
    localparam int CNT_W  = ADDR_W + 1;

    localparam logic [ADDR_W-1:0] LAST_UNIT = ADDR_W'(UNITS - 1);
    localparam logic [15:0]       FAIL_MAX  = 16'hFFFF;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_COMPACT = 2'd1,
        REQ_LOAD    = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_NEXT  = 2'd1,
        POL_BEST  = 2'd2,
        POL_WORST = 2'd3
    } policy_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_COUNT,
        ST_FILL,
        ST_RESP
    } state_t;

    // control from the sequencer to the run scanner
    typedef struct packed {
        logic              init;
        logic              vld;
        logic [ADDR_W-1:0] idx;
        logic              occ;
        policy_t           policy;
        logic [CNT_W-1:0]  size;
    } scan_ctl_t;

    // verdict of the run scanner
    typedef struct packed {
        logic              done;
        logic              hit;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] next_ptr;
    } scan_res_t;

endpackage

/* hdl/cua_occ_mem.sv */
module cua_occ_mem (
    input  logic                       clk,
    input  logic                       we,
    input  logic [cua_pkg::ADDR_W-1:0] waddr,
    input  logic                       wdata,
    input  logic [cua_pkg::ADDR_W-1:0] raddr,
    output logic                       rdata
);
    import cua_pkg::*;

    logic mem [UNITS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hdl/cua_fit_scan.sv */
module cua_fit_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  cua_pkg::scan_ctl_t ctl,
    output cua_pkg::scan_res_t res
);
    import cua_pkg::*;

    logic [CNT_W-1:0]  run_reg, run_next;
    logic [ADDR_W-1:0] begin_reg, begin_next;
    logic              have_reg, have_next;
    logic [CNT_W-1:0]  pick_len_reg, pick_len_next;
    logic [ADDR_W-1:0] pick_start_reg, pick_start_next;
    logic              wrapped_reg, wrapped_next;

    logic [CNT_W-1:0]  run_in;
    logic [CNT_W-1:0]  chk_len;
    logic [ADDR_W-1:0] chk_begin;
    logic              chk_en;
    logic              better;
    logic              fit_now;
    logic              is_last;
    logic              extreme;

    assign extreme = (ctl.policy == POL_BEST) || (ctl.policy == POL_WORST);
    assign is_last = (ctl.idx == LAST_UNIT);
    // a run never carries across the wrap to unit zero
    assign run_in  = (ctl.idx == '0) ? '0 : run_reg;

    // extend or break the current run
    always_comb
    begin
        if (ctl.occ)
        begin
            run_next   = '0;
            begin_next = begin_reg;
            chk_len    = run_in;
            chk_begin  = begin_reg;
            chk_en     = extreme;
        end
        else
        begin
            run_next   = run_in + CNT_W'(1);
            begin_next = (run_in == '0) ? ctl.idx : begin_reg;
            chk_len    = run_next;
            chk_begin  = begin_next;
            chk_en     = extreme && is_last;
        end
    end

    assign fit_now = !ctl.occ && (run_next >= ctl.size);

    // weigh a closed run against the best pick so far
    always_comb
    begin
        better = 1'b0;
        if (chk_en && (chk_len >= ctl.size))
        begin
            if (!have_reg)
            begin
                better = 1'b1;
            end
            else if (ctl.policy == POL_WORST)
            begin
                better = chk_len > pick_len_reg;
            end
            else
            begin
                better = chk_len < pick_len_reg;
            end
        end
    end

    always_comb
    begin
        have_next       = have_reg || better;
        pick_len_next   = better ? chk_len : pick_len_reg;
        pick_start_next = better ? chk_begin : pick_start_reg;
        wrapped_next    = wrapped_reg || is_last;
    end

    // report the outcome of this element
    always_comb
    begin
        res.next_ptr = ctl.idx + ADDR_W'(1);
        if (extreme)
        begin
            res.done  = ctl.vld && is_last;
            res.hit   = have_next;
            res.start = pick_start_next;
        end
        else
        begin
            res.done  = ctl.vld && (fit_now ||
                        (is_last && ((ctl.policy == POL_FIRST) || wrapped_reg)));
            res.hit   = fit_now;
            res.start = begin_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= '0;
            have_reg    <= 1'b0;
            wrapped_reg <= 1'b0;
        end
        else if (ctl.init)
        begin
            run_reg     <= '0;
            have_reg    <= 1'b0;
            wrapped_reg <= 1'b0;
        end
        else if (ctl.vld)
        begin
            run_reg     <= run_next;
            have_reg    <= have_next;
            wrapped_reg <= wrapped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            begin_reg <= '0;
        end
        else if (ctl.vld)
        begin
            begin_reg      <= begin_next;
            pick_len_reg   <= pick_len_next;
            pick_start_reg <= pick_start_next;
        end
    end

endmodule

/* hdl/contiguous_unit_allocator.sv */
// Steps: a load, an unused request and a zero-size allocate go straight to the result state;
// an allocate scans the map, then marks each unit of a hit; a compact counts, then refills the map.
// A result stall holds the block in the result state until the receiver takes the result.
// Throughput: one request at a time; the walk over the occupancy RAM sets the rate.
// Reset: asynchronous, active low; afterwards a clearing pass over all UNITS (65536) units frees
// every unit while in_stall stays high. Policy, pointer and failure count reset to zero.
module contiguous_unit_allocator (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [16:0] run_size,
    input  logic [15:0] unit_index,
    input  logic        unit_free,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        granted,
    output logic [15:0] start_unit,
    output logic [15:0] failed_total
);
    import cua_pkg::*;

    state_t            state_reg, state_next;
    policy_t           fit_policy_reg;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0]  size_reg;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [ADDR_W-1:0] next_start_reg, next_start_next;
    logic [15:0]       fail_reg, fail_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic              res_grant_reg, res_grant_next;
    logic [15:0]       res_start_reg, res_start_next;
    logic              out_valid_reg;
    logic              granted_reg;
    logic [15:0]       start_unit_reg;
    logic [15:0]       failed_total_reg;

    logic              accept;
    logic              cfg_wr;
    logic              out_free;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_wdata;
    logic              mem_rdata;
    scan_ctl_t         sctl;
    scan_res_t         sres;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {30'd0, fit_policy_reg} : 32'd0;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign granted      = granted_reg;
    assign start_unit   = start_unit_reg;
    assign failed_total = failed_total_reg;

    cua_occ_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (ptr_reg),
        .rdata (mem_rdata)
    );

    // feed returning map bits to the scanner
    always_comb
    begin
        sctl.init   = accept;
        sctl.vld    = rd_vld_reg && (state_reg == ST_SCAN);
        sctl.idx    = rd_idx_reg;
        sctl.occ    = mem_rdata;
        sctl.policy = fit_policy_reg;
        sctl.size   = size_reg;
    end

    cua_fit_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sctl),
        .res   (sres)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (ptr_reg == LAST_UNIT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((req_type == REQ_ALLOC) && (run_size != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (req_type == REQ_COMPACT)
                    begin
                        state_next = ST_COUNT;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN:
            begin
                if (sres.done)
                begin
                    state_next = sres.hit ? ST_MARK : ST_RESP;
                end
            end
            ST_MARK:
            begin
                if ((left_reg == CNT_W'(1)) || (ptr_reg == LAST_UNIT))
                begin
                    state_next = ST_RESP;
                end
            end
            ST_COUNT:
            begin
                if (rd_vld_reg && (rd_idx_reg == LAST_UNIT))
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (ptr_reg == LAST_UNIT)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        ptr_next        = ptr_reg;
        left_next       = left_reg;
        used_next       = used_reg;
        next_start_next = next_start_reg;
        fail_next       = fail_reg;
        rd_vld_next     = 1'b0;
        res_grant_next  = res_grant_reg;
        res_start_next  = res_start_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                res_start_next = '0;
                if (accept)
                begin
                    ptr_next       = '0;
                    used_next      = '0;
                    res_grant_next = 1'b1;
                    case (req_type)
                        REQ_ALLOC:
                        begin
                            if (fit_policy_reg == POL_NEXT)
                            begin
                                ptr_next = next_start_reg;
                            end
                            if (run_size == '0)
                            begin
                                res_grant_next = 1'b0;
                                if (fail_reg != FAIL_MAX)
                                begin
                                    fail_next = fail_reg + 16'd1;
                                end
                            end
                        end
                        REQ_LOAD:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = unit_index[ADDR_W-1:0];
                            mem_wdata = !unit_free;
                        end
                        REQ_NONE:
                        begin
                            res_grant_next = 1'b0;
                        end
                        default:
                        begin
                            res_grant_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                ptr_next    = ptr_reg + ADDR_W'(1);
                rd_vld_next = !sres.done;
                if (sres.done)
                begin
                    if (sres.hit)
                    begin
                        ptr_next       = sres.start;
                        left_next      = size_reg;
                        res_start_next = sres.start;
                        if (fit_policy_reg == POL_NEXT)
                        begin
                            next_start_next = sres.next_ptr;
                        end
                    end
                    else
                    begin
                        res_grant_next = 1'b0;
                        if (fail_reg != FAIL_MAX)
                        begin
                            fail_next = fail_reg + 16'd1;
                        end
                    end
                end
            end
            ST_MARK:
            begin
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                ptr_next  = ptr_reg + ADDR_W'(1);
                left_next = left_reg - CNT_W'(1);
            end
            ST_COUNT:
            begin
                ptr_next    = ptr_reg + ADDR_W'(1);
                rd_vld_next = !(rd_vld_reg && (rd_idx_reg == LAST_UNIT));
                if (rd_vld_reg)
                begin
                    used_next = used_reg + CNT_W'(mem_rdata);
                end
                if (!rd_vld_next)
                begin
                    ptr_next = '0;
                end
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = {1'b0, ptr_reg} < used_reg;
                ptr_next  = ptr_reg + ADDR_W'(1);
            end
            ST_RESP:
            begin
                ptr_next = ptr_reg;
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            fit_policy_reg <= POL_FIRST;
            ptr_reg        <= '0;
            next_start_reg <= '0;
            fail_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            next_start_reg <= next_start_next;
            fail_reg       <= fail_next;
            rd_vld_reg     <= rd_vld_next;
            if (cfg_wr)
            begin
                fit_policy_reg <= policy_t'(pwdata[1:0]);
            end
            if ((state_reg == ST_RESP) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= ptr_reg;
        left_reg      <= left_next;
        used_reg      <= used_next;
        res_grant_reg <= res_grant_next;
        res_start_reg <= res_start_next;
        if (accept)
        begin
            size_reg <= run_size;
        end
        if ((state_reg == ST_RESP) && out_free)
        begin
            granted_reg      <= res_grant_reg;
            start_unit_reg   <= res_start_reg;
            failed_total_reg <= fail_reg;
        end
    end

endmodule

/* bench/tb_contiguous_unit_allocator.sv */
module tb_contiguous_unit_allocator;
    import cua_pkg::*;

    localparam int unsigned MAP_UNITS   = 65536;
    localparam int unsigned CYCLE_LIMIT = 100000000;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef struct {
        logic        granted;
        logic [15:0] start_unit;
        logic [15:0] failed_total;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [16:0] run_size;
    logic [15:0] unit_index;
    logic        unit_free;
    logic        out_valid;
    logic        out_stall;
    logic        granted;
    logic [15:0] start_unit;
    logic [15:0] failed_total;

    // shadow of the block state
    bit          occ_map [0:MAP_UNITS-1];
    int unsigned next_ptr;
    int unsigned fail_cnt;
    policy_t     cur_policy;

    grant_t      pending_grants[$];
    int unsigned mismatches;
    int unsigned beats_out;
    int unsigned allocs_sent;
    int unsigned allocs_granted;
    int unsigned compacts_sent;
    int unsigned loads_sent;
    int unsigned burst_left;
    bit          hold_req;
    longint unsigned cycles;

    contiguous_unit_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .run_size     (run_size),
        .unit_index   (unit_index),
        .unit_free    (unit_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .granted      (granted),
        .start_unit   (start_unit),
        .failed_total (failed_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // find and mark a run, return whether one was found and give its start unit
    function automatic bit fit_run(int unsigned sz, output int unsigned at);
        int unsigned i;
        int unsigned run;
        int unsigned first;
        int unsigned steps;
        int unsigned pick_len;
        bit          found;
        found = 0;
        run = 0;
        first = 0;
        at = 0;
        pick_len = 0;
        if (sz == 0)
            return 0;
        case (cur_policy)
            POL_FIRST:
            begin
                for (i = 0; i < MAP_UNITS && !found; i++)
                begin
                    if (occ_map[i])
                        run = 0;
                    else
                    begin
                        if (run == 0)
                            first = i;
                        run++;
                        if (run >= sz)
                        begin
                            at = first;
                            found = 1;
                        end
                    end
                end
            end
            POL_NEXT:
            begin
                i = next_ptr;
                for (steps = 0; steps < MAP_UNITS && !found; steps++)
                begin
                    if (occ_map[i])
                        run = 0;
                    else
                    begin
                        if (run == 0)
                            first = i;
                        run++;
                        if (run >= sz)
                        begin
                            at = first;
                            next_ptr = (i + 1) % MAP_UNITS;
                            found = 1;
                        end
                    end
                    if (!found)
                    begin
                        i++;
                        if (i >= MAP_UNITS)
                            i = 0;
                        if (i == 0)
                            run = 0;
                    end
                end
                // extend the run that reaches the start point
                if (!found)
                begin
                    if (run == 0)
                        first = i;
                    while (i < MAP_UNITS && !found && !occ_map[i])
                    begin
                        run++;
                        if (run >= sz)
                        begin
                            at = first;
                            next_ptr = (i + 1) % MAP_UNITS;
                            found = 1;
                        end
                        i++;
                    end
                end
            end
            default:
            begin
                for (i = 0; i <= MAP_UNITS; i++)
                begin
                    if (i == MAP_UNITS || occ_map[i])
                    begin
                        if (run >= sz && (!found || (cur_policy == POL_WORST ?
                            run > pick_len : run < pick_len)))
                        begin
                            found = 1;
                            pick_len = run;
                            at = first;
                        end
                        run = 0;
                    end
                    else
                    begin
                        if (run == 0)
                            first = i;
                        run++;
                    end
                end
            end
        endcase
        if (found)
            for (i = 0; i < sz && at + i < MAP_UNITS; i++)
                occ_map[at + i] = 1;
        return found;
    endfunction

    function automatic grant_t predict_grant(logic [1:0] rq, logic [16:0] sz,
                                             logic [15:0] idx, logic fr);
        grant_t      g;
        int unsigned at;
        int unsigned used;
        g.granted = 0;
        g.start_unit = 0;
        at = 0;
        used = 0;
        case (rq)
            REQ_ALLOC:
            begin
                if (fit_run(sz, at))
                begin
                    g.granted = 1;
                    g.start_unit = at[15:0];
                end
                else if (fail_cnt < 65535)
                    fail_cnt++;
            end
            REQ_COMPACT:
            begin
                foreach (occ_map[i])
                    used += occ_map[i];
                foreach (occ_map[i])
                    occ_map[i] = (i < used);
                g.granted = 1;
            end
            REQ_LOAD:
            begin
                occ_map[idx] = !fr;
                g.granted = 1;
            end
            default: ;
        endcase
        g.failed_total = fail_cnt[15:0];
        return g;
    endfunction

    // check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_out++;
            if (pending_grants.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (granted !== want.granted)
                begin
                    $error("granted: expected %0d, got %0d", want.granted, granted);
                    mismatches++;
                end
                if (start_unit !== want.start_unit)
                begin
                    $error("start_unit: expected %0d, got %0d", want.start_unit, start_unit);
                    mismatches++;
                end
                if (failed_total !== want.failed_total)
                begin
                    $error("failed_total: expected %0d, got %0d",
                           want.failed_total, failed_total);
                    mismatches++;
                end
            end
        end
    end

    // receiver stall: random stretches, quiet stretches, and a long hold-off on request
    initial
    begin
        int unsigned stretch;
        int unsigned mode;
        int unsigned k;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(negedge clk);
                hold_req = 0;
                out_stall = 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 2);
                stretch = $urandom_range(1, 40);
                for (k = 0; k < stretch && !hold_req; k++)
                begin
                    out_stall = (mode == 0) ? 1'b0 :
                                (mode == 1) ? ($urandom_range(0, 3) == 0) :
                                              ($urandom_range(0, 1) == 0);
                    @(negedge clk);
                end
                out_stall = 1'b0;
            end
        end
    end

    // offer one request beat; called at a falling edge, returns at one
    task automatic send_req(logic [1:0] rq, logic [16:0] sz, logic [15:0] idx, logic fr);
        int unsigned gap;
        in_valid = 1'b1;
        req_type = rq;
        run_size = sz;
        unit_index = idx;
        unit_free = fr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_grants.push_back(predict_grant(rq, sz, idx, fr));
        case (rq)
            REQ_ALLOC:   allocs_sent++;
            REQ_COMPACT: compacts_sent++;
            REQ_LOAD:    loads_sent++;
            default: ;
        endcase
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(0, 6);
        end
        else
            burst_left--;
    endtask

    // wait for every result, then let the block settle
    task automatic drain();
        in_valid = 1'b0;
        while (pending_grants.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_policy(policy_t p);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 3'd0;
        pwdata = {30'd0, p};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cur_policy = p;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // random request, mostly small sizes near the front of the map
    task automatic send_random();
        int unsigned pick;
        logic [16:0] sz;
        logic [15:0] idx;
        pick = $urandom_range(0, 99);
        idx = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
        if ($urandom_range(0, 19) == 0)
            sz = 17'($urandom);
        else
            sz = 17'($urandom_range(1, 24));
        if (pick < 52)
            send_req(REQ_LOAD, 17'($urandom), idx, 1'($urandom));
        else if (pick < 90)
            send_req(REQ_ALLOC, sz, 16'($urandom), 1'($urandom));
        else if (pick < 97)
            send_req(REQ_COMPACT, 17'($urandom), 16'($urandom), 1'($urandom));
        else
            send_req(REQ_NONE, 17'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // field extremes, every request type and the failure cases, under first fit
    task automatic test_directed();
        write_policy(POL_FIRST);
        send_req(REQ_ALLOC, 17'd0, 16'hFFFF, 1'b1);
        send_req(REQ_ALLOC, 17'd65536, 16'd0, 1'b0);
        send_req(REQ_ALLOC, 17'd1, 16'd0, 1'b0);
        send_req(REQ_NONE, 17'h1FFFF, 16'hFFFF, 1'b1);
        send_req(REQ_LOAD, 17'd0, 16'hFFFF, 1'b1);
        send_req(REQ_LOAD, 17'd0, 16'd10, 1'b1);
        send_req(REQ_LOAD, 17'd0, 16'd11, 1'b1);
        send_req(REQ_ALLOC, 17'd2, 16'd0, 1'b0);
        send_req(REQ_ALLOC, 17'd1, 16'd0, 1'b0);
        send_req(REQ_ALLOC, 17'h1FFFF, 16'd0, 1'b0);
        send_req(REQ_LOAD, 17'd0, 16'd0, 1'b1);
        send_req(REQ_LOAD, 17'd0, 16'd5, 1'b1);
        send_req(REQ_COMPACT, 17'd0, 16'd0, 1'b0);
        send_req(REQ_ALLOC, 17'd3, 16'd0, 1'b0);
        send_req(REQ_LOAD, 17'd0, 16'hFFFF, 1'b0);
        drain();
    endtask

    // structured fragmentation, then the same mix under each policy
    task automatic test_policies();
        policy_t pols [4];
        int unsigned p;
        int unsigned k;
        pols = '{POL_NEXT, POL_BEST, POL_WORST, POL_FIRST};
        for (p = 0; p < 4; p++)
        begin
            write_policy(pols[p]);
            // open single-unit holes at the front of the map
            for (k = 0; k < 10; k++)
                send_req(REQ_LOAD, 17'd0, 16'(k * 3 + (k & 1)), 1'b1);
            send_req(REQ_LOAD, 17'd0, 16'd65534, 1'b1);
            send_req(REQ_ALLOC, 17'd1, 16'd0, 1'b0);
            send_req(REQ_ALLOC, 17'd2, 16'd0, 1'b0);
            send_req(REQ_ALLOC, 17'd1, 16'd0, 1'b0);
            send_req(REQ_ALLOC, 17'd1, 16'd0, 1'b0);
            drain();
        end
    endtask

    task automatic test_random(int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++)
        begin
            if (k % 5 == 0)
            begin
                drain();
                write_policy(policy_t'($urandom_range(0, 3)));
            end
            send_random();
        end
        drain();
    endtask

    // hold the result side while loads keep coming, then pause the sender
    task automatic test_backpressure();
        int unsigned k;
        hold_req = 1;
        for (k = 0; k < 8; k++)
            send_req(REQ_LOAD, 17'd0, 16'($urandom_range(0, 63)), 1'($urandom));
        send_req(REQ_ALLOC, 17'd2, 16'd0, 1'b0);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        req_type = '0;
        run_size = '0;
        unit_index = '0;
        unit_free = 1'b0;
        hold_req = 0;
        cycles = 0;
        mismatches = 0;
        beats_out = 0;
        allocs_sent = 0;
        allocs_granted = 0;
        compacts_sent = 0;
        loads_sent = 0;
        burst_left = 0;
        next_ptr = 0;
        fail_cnt = 0;
        cur_policy = POL_FIRST;
        foreach (occ_map[i])
            occ_map[i] = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        // let the clearing pass finish
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);

        test_directed();
        test_policies();
        test_backpressure();
        test_random(20);

        repeat (20) @(negedge clk);
        $display("Covered %0d allocates, %0d compacts, %0d loads under all four fit policies;",
                 allocs_sent, compacts_sent, loads_sent);
        $display("%0d result beats checked, %0d still pending.",
                 beats_out, pending_grants.size());
        if (mismatches == 0 && pending_grants.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
hdl/cua_pkg.sv
hdl/cua_occ_mem.sv
hdl/cua_fit_scan.sv
hdl/contiguous_unit_allocator.sv
bench/tb_contiguous_unit_allocator.sv
